// ----- rtl/core/hlcc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlcc_pkg
// Shared types and constants of the heater link command controller.
// ---------------------------------------------------------------------------
package hlcc_pkg;

   localparam int FRAME_BYTES = 10;
   localparam int IDX_W       = 4;

   localparam logic [7:0] TAG_TEMP = 8'hdd;
   localparam logic [7:0] TAG_CTRL = 8'hd2;
   localparam logic [7:0] TAG_CMD  = 8'hcc;

   localparam logic [2:0] CMD_RX    = 3'd0;
   localparam logic [2:0] CMD_TICK  = 3'd1;
   localparam logic [2:0] CMD_POWER = 3'd2;
   localparam logic [2:0] CMD_MODE  = 3'd3;
   localparam logic [2:0] CMD_TEMP  = 3'd4;

   // what a command frame patches
   typedef enum logic [1:0] {
      PATCH_POWER = 2'd0,
      PATCH_MODE  = 2'd1,
      PATCH_TEMP  = 2'd2
   } patch_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_in;     // capture the accepted item
      logic       rx_store;    // store received byte, judge frame if complete
      logic       tick_eval;   // run the sequencer tick
      logic       req_eval;    // run a power/mode/temp request
      logic       emit_frame;  // present frame byte at index
      logic       emit_status; // present status report
      logic       commit;      // adopt built frame after the last byte goes
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic send;              // a frame is to be sent for this item
   } dp_sts_type;

   typedef logic [7:0] frame_type [FRAME_BYTES];

endpackage

// ----- rtl/core/heater_link_command_controller.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heater_link_command_controller
// Heater link controller: frame receive, status decode, command send.
// ---------------------------------------------------------------------------
//  channel | ports                   | direction
//  req     | req_valid/req_ready     | in, received byte / tick / request
//  rsp     | rsp_valid/rsp_ready     | out, frame bytes then status
//  csr     | csr_we/csr_wdata        | in, wait_ticks write
//
// An item runs evaluate, the ten command frame bytes if a frame goes out,
// then status, held by output stalls; the one-item controller takes no new
// item before that. Synchronous active-high reset puts wait_ticks at 500 and clears
// both stored frames, status and sequencer. A stalled rsp holds the transfer.
module heater_link_command_controller import hlcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_first,
   input  logic        req_power_req,
   input  logic [1:0]  req_mode_req,
   input  logic [7:0]  req_temp_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic [7:0]  rsp_temp_in,
   output logic [7:0]  rsp_temp_out,
   output logic [7:0]  rsp_ambient,
   output logic [7:0]  rsp_error_code,
   output logic        rsp_power_on,
   output logic [1:0]  rsp_mode,
   output logic [6:0]  rsp_target_temp,
   output logic        rsp_state_changed
);

   dp_cmd_type       dp_cmd;
   dp_sts_type       dp_sts;
   logic [IDX_W-1:0] byte_idx;

   // controller: one item at a time
   hlcc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_cmd,
      .rsp_valid, .rsp_ready, .byte_idx, .dp_cmd, .dp_sts
   );

   // datapath: frames, status, sequencer
   hlcc_dp u_dp (
      .clock, .reset, .csr_we, .csr_wdata,
      .req_rx_byte, .req_rx_first, .req_power_req, .req_mode_req,
      .req_temp_req, .req_cmd, .byte_idx, .dp_cmd, .dp_sts,
      .rsp_kind, .rsp_tx_byte, .rsp_last, .rsp_temp_in, .rsp_temp_out,
      .rsp_ambient, .rsp_error_code, .rsp_power_on, .rsp_mode,
      .rsp_target_temp, .rsp_state_changed
   );

endmodule

// ----- rtl/core/hlcc_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlcc_ctrl
// Sequencer of one item: evaluate, send ten frame bytes if a frame is to go out, send status.
// ---------------------------------------------------------------------------
module hlcc_ctrl import hlcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [IDX_W-1:0] byte_idx,
   output dp_cmd_type dp_cmd,
   input  dp_sts_type dp_sts
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVAL   = 4'b0010,
      ST_FRAME  = 4'b0100,
      ST_STATUS = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       cmd_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) cmd_ff <= req_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = ((state_ff == ST_FRAME) && dp_sts.send) || (state_ff == ST_STATUS);
   assign byte_idx  = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            dp_cmd.load_in = req_valid;
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            dp_cmd.rx_store  = (cmd_ff == CMD_RX);
            dp_cmd.tick_eval = (cmd_ff == CMD_TICK);
            dp_cmd.req_eval  = (cmd_ff == CMD_POWER) || (cmd_ff == CMD_MODE) ||
                               (cmd_ff == CMD_TEMP);
            idx_in   = '0;
            state_in = ST_FRAME;
         end
         ST_FRAME: begin
            if (!dp_sts.send) begin
               state_in = ST_STATUS;
            end else begin
               dp_cmd.emit_frame = 1'b1;
               if (rsp_ready) begin
                  if (idx_ff == IDX_W'(FRAME_BYTES - 1)) begin
                     dp_cmd.commit = 1'b1;
                     state_in      = ST_STATUS;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         ST_STATUS: begin
            dp_cmd.emit_status = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < IDX_W'(FRAME_BYTES)) else $error("byte index out of range");
   a_eval_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_EVAL)
      else $error("accepted item not evaluated");
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STATUS && rsp_ready) |=> state_ff == ST_IDLE)
      else $error("status transfer did not finish item");
`endif

endmodule

// ----- rtl/core/hlcc_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlcc_dp
// Frame storage, status decode, command frame build and sequencer state.
// ---------------------------------------------------------------------------
module hlcc_dp import hlcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [15:0] csr_wdata,
   input  logic [7:0] req_rx_byte,
   input  logic       req_rx_first,
   input  logic       req_power_req,
   input  logic [1:0] req_mode_req,
   input  logic [7:0] req_temp_req,
   input  logic [2:0] req_cmd,
   input  logic [IDX_W-1:0] byte_idx,
   input  dp_cmd_type dp_cmd,
   output dp_sts_type dp_sts,
   output logic       rsp_kind,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic [7:0] rsp_temp_in,
   output logic [7:0] rsp_temp_out,
   output logic [7:0] rsp_ambient,
   output logic [7:0] rsp_error_code,
   output logic       rsp_power_on,
   output logic [1:0] rsp_mode,
   output logic [6:0] rsp_target_temp,
   output logic       rsp_state_changed
);

   logic [15:0] wait_ff;
   logic [7:0]  byte_ff, temp_ff;
   logic        first_ff, pow_ff;
   logic [1:0]  mreq_ff;
   logic [2:0]  cmd_ff;

   logic [7:0]  rxb_ff  [FRAME_BYTES];
   logic [7:0]  tfr_ff  [FRAME_BYTES];
   logic [7:0]  cfr_ff  [FRAME_BYTES];
   logic [7:0]  bld_ff  [FRAME_BYTES];
   logic [3:0]  cnt_ff;
   logic [1:0]  step_ff;
   logic [15:0] elap_ff;
   logic [7:0]  pend_ff;
   logic        rest_ff;
   logic        send_ff, chg_ff;
   logic [7:0]  st_tin_ff, st_tout_ff, st_amb_ff, st_err_ff;
   logic        st_pow_ff;
   logic [1:0]  st_mode_ff;
   logic [6:0]  st_tgt_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_in) begin
         byte_ff  <= req_rx_byte;
         first_ff <= req_rx_first;
         pow_ff   <= req_power_req;
         mreq_ff  <= req_mode_req;
         temp_ff  <= req_temp_req;
         cmd_ff   <= req_cmd;
      end
   end

   // receive path
   logic [3:0] cidx;
   logic [IDX_W-1:0] widx;
   logic       full;
   logic [7:0] nf [FRAME_BYTES];
   logic       diff_t, diff_c;
   always_comb begin
      cidx = (first_ff || cnt_ff >= 4'(FRAME_BYTES)) ? 4'd0 : cnt_ff;
      widx = cidx;
      full = (cidx == 4'(FRAME_BYTES - 1));
      for (int i = 0; i < FRAME_BYTES; i++)
         nf[i] = (widx == IDX_W'(i)) ? byte_ff : rxb_ff[i];
      diff_t = 1'b0;
      diff_c = 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (nf[i] != tfr_ff[i]) diff_t = 1'b1;
         if (nf[i] != cfr_ff[i]) diff_c = 1'b1;
      end
   end

   // request / tick decision
   logic       do_send, ok;
   patch_type  what;
   logic [7:0] val;
   logic [1:0] step_nx;
   logic       step_we, elap_clr, pend_we;
   logic [15:0] elap_inc;
   always_comb begin
      ok       = (cfr_ff[0] == TAG_CTRL);
      do_send  = 1'b0;
      what     = PATCH_POWER;
      val      = 8'd0;
      step_nx  = step_ff;
      step_we  = 1'b0;
      elap_clr = 1'b0;
      pend_we  = 1'b0;
      elap_inc = (elap_ff != 16'hffff) ? elap_ff + 16'd1 : elap_ff;
      if (dp_cmd.tick_eval && step_ff != 2'd0) begin
         if (elap_inc >= wait_ff) begin
            step_we = 1'b1;
            do_send = ok;
            if (step_ff == 2'd1) begin
               what = PATCH_TEMP;
               val  = pend_ff;
               step_nx  = rest_ff ? 2'd2 : 2'd0;
               elap_clr = rest_ff;
            end else begin
               what    = PATCH_POWER;
               val     = 8'd1;
               step_nx = 2'd0;
            end
         end
      end else if (dp_cmd.req_eval) begin
         priority case (1'b1)
            cmd_ff == CMD_POWER: begin
               do_send = ok;
               val     = {7'd0, pow_ff};
            end
            cmd_ff == CMD_MODE: begin
               if (mreq_ff == 2'd0) begin
                  do_send = ok;
               end else if (step_ff == 2'd0) begin
                  do_send  = ok;
                  what     = PATCH_MODE;
                  val      = {6'd0, mreq_ff};
                  step_we  = 1'b1;
                  step_nx  = 2'd3;
                  elap_clr = 1'b1;
               end
            end
            default: begin
               if (step_ff == 2'd0) begin
                  pend_we = 1'b1;
                  do_send = ok;
                  if (st_pow_ff) begin
                     step_we  = 1'b1;
                     step_nx  = 2'd1;
                     elap_clr = 1'b1;
                  end else begin
                     what = PATCH_TEMP;
                     val  = temp_ff;
                  end
               end
            end
         endcase
      end
   end

   // build patched frame
   logic [7:0] bf [FRAME_BYTES];
   logic [7:0] sum;
   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) bf[i] = cfr_ff[i];
      unique case (what)
         PATCH_POWER: bf[7] = (bf[7] & 8'hBF) | (val[0] ? 8'h40 : 8'h00);
         PATCH_MODE: begin
            if (val[1:0] == 2'd1) begin
               bf[7] = bf[7] & 8'hDF;
               bf[8] = bf[8] | 8'h80;
            end else if (val[1:0] == 2'd2) begin
               bf[7] = bf[7] & 8'hDF;
               bf[8] = bf[8] & 8'h7F;
            end else begin
               bf[7] = bf[7] | 8'h20;
               bf[8] = bf[8] & 8'h7F;
            end
         end
         default: bf[2] = (bf[2] & 8'h80) | (val & 8'h7F);
      endcase
      bf[0] = TAG_CMD;
      sum = 8'd0;
      for (int i = 1; i < FRAME_BYTES - 1; i++) sum = sum + bf[i];
      bf[FRAME_BYTES - 1] = sum;
   end

   // decode of a control frame into status
   function automatic logic [9:0] dec_ctrl(input logic [7:0] b2, input logic [7:0] b7,
                                          input logic [7:0] b8);
      logic       p;
      logic [1:0] m;
      p = b7[6];
      if (!p)          m = 2'd0;
      else if (b8[7])  m = 2'd1;
      else if (!b7[5]) m = 2'd2;
      else             m = 2'd3;
      return {p, m, b2[6:0]};
   endfunction

   logic [9:0] dc_rx, dc_bld;
   assign dc_rx  = dec_ctrl(nf[2], nf[7], nf[8]);
   assign dc_bld = dec_ctrl(bld_ff[2], bld_ff[7], bld_ff[8]);

   always_ff @(posedge clock) begin
      if (dp_cmd.rx_store) rxb_ff[widx] <= byte_ff;
      if (dp_cmd.req_eval || dp_cmd.tick_eval) begin
         for (int i = 0; i < FRAME_BYTES; i++) bld_ff[i] <= bf[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= 16'd500;
         cnt_ff  <= '0;
         step_ff <= '0;
         elap_ff <= '0;
         pend_ff <= '0;
         rest_ff <= 1'b0;
         send_ff <= 1'b0;
         chg_ff  <= 1'b0;
         for (int i = 0; i < FRAME_BYTES; i++) begin
            tfr_ff[i] <= '0;
            cfr_ff[i] <= '0;
         end
         st_tin_ff <= '0; st_tout_ff <= '0; st_amb_ff <= '0; st_err_ff <= '0;
         st_pow_ff <= 1'b0; st_mode_ff <= '0; st_tgt_ff <= '0;
      end else begin
         if (csr_we) wait_ff <= csr_wdata;
         if (dp_cmd.load_in) begin
            send_ff <= 1'b0;
            chg_ff  <= 1'b0;
         end
         if (dp_cmd.rx_store) begin
            cnt_ff <= full ? 4'd0 : cidx + 4'd1;
            if (full && nf[0] == TAG_TEMP && diff_t) begin
               for (int i = 0; i < FRAME_BYTES; i++) tfr_ff[i] <= nf[i];
               st_tin_ff  <= nf[1];
               st_tout_ff <= nf[2];
               st_amb_ff  <= nf[5];
               st_err_ff  <= nf[7];
               chg_ff     <= 1'b1;
            end else if (full && nf[0] == TAG_CTRL && diff_c) begin
               for (int i = 0; i < FRAME_BYTES; i++) cfr_ff[i] <= nf[i];
               {st_pow_ff, st_mode_ff, st_tgt_ff} <= dc_rx;
               chg_ff <= 1'b1;
            end
         end
         if (dp_cmd.tick_eval && step_ff != 2'd0) elap_ff <= elap_clr ? 16'd0 : elap_inc;
         if (dp_cmd.req_eval && elap_clr) elap_ff <= 16'd0;
         if (step_we) step_ff <= step_nx;
         if (pend_we) begin
            pend_ff <= temp_ff;
            rest_ff <= st_pow_ff;
         end
         if (dp_cmd.req_eval || dp_cmd.tick_eval) send_ff <= do_send;
         if (dp_cmd.commit) begin
            for (int i = 1; i < FRAME_BYTES; i++) cfr_ff[i] <= bld_ff[i];
            cfr_ff[0] <= TAG_CTRL;
            {st_pow_ff, st_mode_ff, st_tgt_ff} <= dc_bld;
            chg_ff <= 1'b1;
         end
      end
   end

   assign dp_sts.send = send_ff;

   always_comb begin
      rsp_kind          = dp_cmd.emit_status;
      rsp_last          = dp_cmd.emit_status;
      rsp_tx_byte       = dp_cmd.emit_frame ? bld_ff[byte_idx] : 8'd0;
      rsp_temp_in       = rsp_kind ? st_tin_ff  : 8'd0;
      rsp_temp_out      = rsp_kind ? st_tout_ff : 8'd0;
      rsp_ambient       = rsp_kind ? st_amb_ff  : 8'd0;
      rsp_error_code    = rsp_kind ? st_err_ff  : 8'd0;
      rsp_power_on      = rsp_kind & st_pow_ff;
      rsp_mode          = rsp_kind ? st_mode_ff : 2'd0;
      rsp_target_temp   = rsp_kind ? st_tgt_ff  : 7'd0;
      rsp_state_changed = rsp_kind & chg_ff;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < 4'(FRAME_BYTES)) else $error("rx count out of range");
   a_commit_tag: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |=> cfr_ff[0] == TAG_CTRL) else $error("commit lost control tag");
   a_commit_send: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> send_ff) else $error("commit without a send");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the heater link command controller. An internal
// model of the frame store, status decode and command sequencer predicts
// every frame byte and status report; a monitor compares each rsp transfer
// against the oldest prediction, with random req gaps and rsp stalls.
// ---------------------------------------------------------------------------
module tb;
   import hlcc_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic       last;
      logic [7:0] temp_in;
      logic [7:0] temp_out;
      logic [7:0] ambient;
      logic [7:0] error_code;
      logic       power_on;
      logic [1:0] mode;
      logic [6:0] target_temp;
      logic       state_changed;
   } rsp_item_t;

   logic        clock, reset;
   logic        csr_we;
   logic [15:0] csr_wdata;
   logic        req_valid, req_ready;
   logic [2:0]  req_cmd;
   logic [7:0]  req_rx_byte;
   logic        req_rx_first, req_power_req;
   logic [1:0]  req_mode_req;
   logic [7:0]  req_temp_req;
   logic        rsp_valid, rsp_ready;
   rsp_item_t   rsp_got;

   heater_link_command_controller u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_rx_byte(req_rx_byte), .req_rx_first(req_rx_first),
      .req_power_req(req_power_req), .req_mode_req(req_mode_req),
      .req_temp_req(req_temp_req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_got.kind), .rsp_tx_byte(rsp_got.tx_byte),
      .rsp_last(rsp_got.last), .rsp_temp_in(rsp_got.temp_in),
      .rsp_temp_out(rsp_got.temp_out), .rsp_ambient(rsp_got.ambient),
      .rsp_error_code(rsp_got.error_code), .rsp_power_on(rsp_got.power_on),
      .rsp_mode(rsp_got.mode), .rsp_target_temp(rsp_got.target_temp),
      .rsp_state_changed(rsp_got.state_changed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---- shadow of the controller state --------------------------------
   logic [7:0]  m_rx_buf [FRAME_BYTES];
   logic [3:0]  m_rx_cnt;
   logic [7:0]  m_temp_frame [FRAME_BYTES];
   logic [7:0]  m_ctrl_frame [FRAME_BYTES];
   logic [1:0]  m_step;          // 0 idle, 1 wait/set temp, 2,3 wait/power on
   logic [15:0] m_elapsed;
   logic [7:0]  m_pend_temp;
   logic        m_restore;
   logic [15:0] m_wait_ticks;
   logic [7:0]  s_tin, s_tout, s_amb, s_err;
   logic        s_pwr;
   logic [1:0]  s_mode;
   logic [6:0]  s_target;
   logic        m_changed;

   rsp_item_t expected_rsp_q [$];

   int  errors;
   int  send_idle_pct, stall_pct;

   // ---- idle profile --------------------------------------------------
   task automatic set_idle(input int s, input int r);
      send_idle_pct = s;
      stall_pct     = r;
   endtask

   function automatic void reset_shadow();
      for (int i = 0; i < FRAME_BYTES; i++) begin
         m_rx_buf[i] = '0; m_temp_frame[i] = '0; m_ctrl_frame[i] = '0;
      end
      m_rx_cnt = '0; m_step = '0; m_elapsed = '0; m_pend_temp = '0; m_restore = 1'b0;
      m_wait_ticks = 16'd500;
      {s_tin, s_tout, s_amb, s_err, s_pwr, s_mode, s_target} = '0;
   endfunction

   function automatic void push_tx(input logic [7:0] b);
      rsp_item_t r;
      r = '0;
      r.tx_byte = b;
      expected_rsp_q.push_back(r);
   endfunction

   function automatic void decode_ctrl();
      s_pwr = m_ctrl_frame[7][6];
      if (!s_pwr)              s_mode = 2'd0;
      else if (m_ctrl_frame[8][7]) s_mode = 2'd1;
      else if (!m_ctrl_frame[7][5]) s_mode = 2'd2;
      else                     s_mode = 2'd3;
      s_target = m_ctrl_frame[2][6:0];
   endfunction

   // build, emit and adopt one command frame
   function automatic void build_command(input patch_type what, input logic [7:0] val);
      logic [7:0] f [FRAME_BYTES];
      logic [7:0] sum;
      if (m_ctrl_frame[0] != TAG_CTRL) return;
      for (int i = 0; i < FRAME_BYTES; i++) f[i] = m_ctrl_frame[i];
      case (what)
         PATCH_POWER: f[7][6] = val[0];
         PATCH_MODE: begin
            case (val[1:0])
               2'd1: begin f[7][5] = 1'b0; f[8][7] = 1'b1; end
               2'd2: begin f[7][5] = 1'b0; f[8][7] = 1'b0; end
               2'd3: begin f[7][5] = 1'b1; f[8][7] = 1'b0; end
               default: return;
            endcase
         end
         default: f[2] = {f[2][7], val[6:0]};
      endcase
      f[0] = TAG_CMD;
      sum = '0;
      for (int i = 1; i < FRAME_BYTES - 1; i++) sum += f[i];
      f[FRAME_BYTES-1] = sum;
      for (int i = 0; i < FRAME_BYTES; i++) push_tx(f[i]);
      for (int i = 0; i < FRAME_BYTES; i++) m_ctrl_frame[i] = f[i];
      m_ctrl_frame[0] = TAG_CTRL;
      decode_ctrl();
      m_changed = 1'b1;
   endfunction

   function automatic void judge_frame();
      bit differs;
      differs = 1'b0;
      if (m_rx_buf[0] == TAG_TEMP) begin
         for (int i = 0; i < FRAME_BYTES; i++)
            if (m_temp_frame[i] != m_rx_buf[i]) differs = 1'b1;
         if (differs) begin
            for (int i = 0; i < FRAME_BYTES; i++) m_temp_frame[i] = m_rx_buf[i];
            s_tin = m_temp_frame[1]; s_tout = m_temp_frame[2];
            s_amb = m_temp_frame[5]; s_err = m_temp_frame[7];
            m_changed = 1'b1;
         end
      end else if (m_rx_buf[0] == TAG_CTRL) begin
         for (int i = 0; i < FRAME_BYTES; i++)
            if (m_ctrl_frame[i] != m_rx_buf[i]) differs = 1'b1;
         if (differs) begin
            for (int i = 0; i < FRAME_BYTES; i++) m_ctrl_frame[i] = m_rx_buf[i];
            decode_ctrl();
            m_changed = 1'b1;
         end
      end
   endfunction

   function automatic void sequencer_tick();
      if (m_step == 0) return;
      if (m_elapsed != 16'hffff) m_elapsed++;
      if (m_elapsed < m_wait_ticks) return;
      if (m_step == 1) begin
         build_command(PATCH_TEMP, m_pend_temp);
         if (m_restore) begin
            m_step = 2'd2; m_elapsed = '0;
         end else begin
            m_step = '0;
         end
      end else begin
         build_command(PATCH_POWER, 8'd1);
         m_step = '0;
      end
   endfunction

   // predict all results of one accepted item
   function automatic void predict_item(input logic [2:0] cmd, input logic [7:0] rxb,
                                        input logic first, input logic pwr,
                                        input logic [1:0] md, input logic [7:0] tmp);
      rsp_item_t st;
      logic was_on;
      m_changed = 1'b0;
      case (cmd)
         CMD_RX: begin
            if (first || m_rx_cnt >= FRAME_BYTES) m_rx_cnt = '0;
            m_rx_buf[m_rx_cnt] = rxb;
            m_rx_cnt++;
            if (m_rx_cnt >= FRAME_BYTES) begin
               judge_frame();
               m_rx_cnt = '0;
            end
         end
         CMD_TICK:  sequencer_tick();
         CMD_POWER: build_command(PATCH_POWER, {7'd0, pwr});
         CMD_MODE: begin
            if (md == 2'd0) build_command(PATCH_POWER, 8'd0);
            else if (m_step == 0) begin
               build_command(PATCH_MODE, {6'd0, md});
               m_step = 2'd3; m_elapsed = '0;
            end
         end
         CMD_TEMP: begin
            if (m_step == 0) begin
               was_on = s_pwr;
               m_pend_temp = tmp;
               m_restore = was_on;
               if (was_on) begin
                  build_command(PATCH_POWER, 8'd0);
                  m_step = 2'd1; m_elapsed = '0;
               end else begin
                  build_command(PATCH_TEMP, tmp);
               end
            end
         end
         default: ;
      endcase
      st = '{kind: 1'b1, tx_byte: 8'd0, last: 1'b1, temp_in: s_tin, temp_out: s_tout,
             ambient: s_amb, error_code: s_err, power_on: s_pwr, mode: s_mode,
             target_temp: s_target, state_changed: m_changed};
      expected_rsp_q.push_back(st);
   endfunction

   // ---- driving -------------------------------------------------------
   // req_valid stays high after the transfer until the next idle cycle or drain
   task automatic send_item(input logic [2:0] cmd, input logic [7:0] rxb,
                            input logic first, input logic pwr,
                            input logic [1:0] md, input logic [7:0] tmp);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd; req_rx_byte <= rxb; req_rx_first <= first;
      req_power_req <= pwr; req_mode_req <= md; req_temp_req <= tmp;
      predict_item(cmd, rxb, first, pwr, md, tmp);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_cmd_only(input logic [2:0] cmd);
      send_item(cmd, 8'($urandom), 1'b0, 1'($urandom), 2'($urandom), 8'($urandom));
   endtask

   // one whole received frame; bytes 1..9 random unless given
   task automatic send_frame(input logic [7:0] tag, input logic [7:0] b7,
                             input logic [7:0] b8, input logic [7:0] b2);
      logic [7:0] f [FRAME_BYTES];
      for (int i = 0; i < FRAME_BYTES; i++) f[i] = 8'($urandom);
      f[0] = tag; f[7] = b7; f[8] = b8; f[2] = b2;
      for (int i = 0; i < FRAME_BYTES; i++)
         send_item(CMD_RX, f[i], i == 0, 1'($urandom), 2'($urandom), 8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_wait_ticks(input logic [15:0] v);
      drain();
      csr_we <= 1'b1; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      m_wait_ticks = v;
   endtask

   // ---- response check ------------------------------------------------
   initial begin
      rsp_item_t exp_r;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected rsp transfer");
               errors++;
            end else begin
               exp_r = expected_rsp_q.pop_front();
               if (rsp_got.kind != exp_r.kind) begin
                  $error("kind exp %0h got %0h", exp_r.kind, rsp_got.kind); errors++; end
               if (rsp_got.tx_byte != exp_r.tx_byte) begin
                  $error("tx_byte exp %0h got %0h", exp_r.tx_byte, rsp_got.tx_byte);
                  errors++; end
               if (rsp_got.last != exp_r.last) begin
                  $error("last exp %0h got %0h", exp_r.last, rsp_got.last); errors++; end
               if (rsp_got.temp_in != exp_r.temp_in) begin
                  $error("temp_in exp %0h got %0h", exp_r.temp_in, rsp_got.temp_in);
                  errors++; end
               if (rsp_got.temp_out != exp_r.temp_out) begin
                  $error("temp_out exp %0h got %0h", exp_r.temp_out, rsp_got.temp_out);
                  errors++; end
               if (rsp_got.ambient != exp_r.ambient) begin
                  $error("ambient exp %0h got %0h", exp_r.ambient, rsp_got.ambient);
                  errors++; end
               if (rsp_got.error_code != exp_r.error_code) begin
                  $error("error_code exp %0h got %0h", exp_r.error_code,
                         rsp_got.error_code);
                  errors++; end
               if (rsp_got.power_on != exp_r.power_on) begin
                  $error("power_on exp %0h got %0h", exp_r.power_on, rsp_got.power_on);
                  errors++; end
               if (rsp_got.mode != exp_r.mode) begin
                  $error("mode exp %0h got %0h", exp_r.mode, rsp_got.mode); errors++; end
               if (rsp_got.target_temp != exp_r.target_temp) begin
                  $error("target_temp exp %0h got %0h", exp_r.target_temp,
                         rsp_got.target_temp);
                  errors++; end
               if (rsp_got.state_changed != exp_r.state_changed) begin
                  $error("state_changed exp %0h got %0h", exp_r.state_changed,
                         rsp_got.state_changed);
                  errors++; end
            end
         end
         // rsp_ready is blocking-free here: drive for the next edge
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // ---- tests ---------------------------------------------------------
   // commands before any control frame is known: no command frame goes out
   task automatic test_no_ctrl_frame();
      send_item(CMD_POWER, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00);
      send_item(CMD_MODE,  8'h00, 1'b0, 1'b0, 2'd3, 8'h00);
      send_item(CMD_TEMP,  8'h00, 1'b0, 1'b0, 2'd0, 8'hff);
      send_cmd_only(CMD_TICK);
   endtask

   // frame receipt: temp frame, ctrl frame, partial frame cut by a restart,
   // bad tag, unknown cmd codes
   task automatic test_frames();
      send_frame(TAG_TEMP, 8'hff, 8'h00, 8'h00);
      send_frame(TAG_CTRL, 8'h40, 8'h80, 8'hff);
      for (int i = 0; i < 3; i++)
         send_item(CMD_RX, 8'h55, i == 0, 1'b0, 2'd0, 8'h00);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00);
      send_item(3'd5, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00);
      send_item(3'd7, 8'hff, 1'b1, 1'b1, 2'd3, 8'hff);
   endtask

   // power, mode and temperature sequences with wait_ticks at zero
   task automatic test_commands();
      write_wait_ticks(16'd0);
      send_item(CMD_POWER, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00);
      send_item(CMD_TEMP,  8'h00, 1'b0, 1'b0, 2'd0, 8'h7f);  // off: direct set
      send_item(CMD_POWER, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00);
      send_item(CMD_TEMP,  8'h00, 1'b0, 1'b0, 2'd0, 8'h80);  // on: off/set/on
      send_item(CMD_MODE,  8'h00, 1'b0, 1'b0, 2'd1, 8'h00);  // busy: ignored
      send_cmd_only(CMD_TICK);
      send_cmd_only(CMD_TICK);
      for (int m = 1; m < 4; m++) begin
         send_item(CMD_MODE, 8'h00, 1'b0, 1'b0, m[1:0], 8'h00);
         send_cmd_only(CMD_TICK);
      end
      send_item(CMD_MODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00);
      // idle ticks are ignored
      send_cmd_only(CMD_TICK);
   endtask

   // wait_ticks at its top: the sequencer stays busy
   task automatic test_long_wait();
      write_wait_ticks(16'hffff);
      send_item(CMD_MODE, 8'h00, 1'b0, 1'b0, 2'd2, 8'h00);
      send_cmd_only(CMD_TICK);
      send_item(CMD_TEMP, 8'h00, 1'b0, 1'b0, 2'd0, 8'h33);   // ignored
      send_item(CMD_MODE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00);   // off still acts
      send_item(CMD_POWER, 8'h00, 1'b0, 1'b1, 2'd0, 8'h00);
   endtask

   // random traffic: mostly whole frames and command/tick runs
   task automatic test_random(input int n_items, input logic [15:0] wt);
      int sent;
      int sel;
      write_wait_ticks(wt);
      sent = 0;
      while (sent < n_items) begin
         sel = $urandom_range(9, 0);
         if (sel < 3) begin
            send_frame(($urandom_range(3, 0) == 0) ? 8'($urandom) :
                       (sel == 0 ? TAG_TEMP : TAG_CTRL),
                       8'($urandom), 8'($urandom), 8'($urandom));
            sent += FRAME_BYTES;
         end else if (sel < 6) begin
            send_cmd_only(CMD_TICK);
            sent++;
         end else if (sel < 9) begin
            send_item(3'($urandom_range(4, 2)), 8'($urandom), 1'($urandom),
                      1'($urandom), 2'($urandom), 8'($urandom));
            sent++;
         end else begin
            send_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                      2'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   // ---- main sequence -------------------------------------------------
   initial begin
      errors = 0;
      set_idle(0, 0);
      reset_shadow();
      reset = 1'b1;
      csr_we = 1'b0; csr_wdata = '0;
      req_valid = 1'b0; req_cmd = CMD_RX; req_rx_byte = '0; req_rx_first = 1'b0;
      req_power_req = 1'b0; req_mode_req = '0; req_temp_req = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_ctrl_frame();
      test_frames();
      test_commands();
      test_long_wait();
      set_idle(45, 0);
      test_random(20, 16'd1);
      // pause until every result has come back, then carry on
      drain();
      set_idle(0, 45);
      test_random(20, 16'd2);
      set_idle(6, 6);
      test_random(16, 16'd0);
      set_idle(0, 0);
      test_random(16, 16'd500);

      drain();
      if (errors == 0) $display("tb: clean");
      else             $display("tb: errors");
      $finish;
   end

   // watchdog: far beyond a worst case of ~150 items x 11 results x stalls
   initial begin
      #20ms;
      $display("tb: errors");
      $finish;
   end

endmodule
